FILE: sv/rwlt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reader/writer lock table: shared definitions
// Request codes, fixed port widths and the control structs that pass
// between the lock cells and the top level.
// ----------------------------------------------------------------------------
package rwlt_pkg;

	localparam int FUNC_W    = 3;
	localparam int KEY_IN_W  = 32;
	localparam int CNT_OUT_W = 16;

	localparam logic [FUNC_W-1:0] FN_REGISTER  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DROP      = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ACQ_READ  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_REL_READ  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_ACQ_WRITE = 3'd4;
	localparam logic [FUNC_W-1:0] FN_REL_WRITE = 3'd5;

	// Control part of the lookup word that walks down the row of cells.
	typedef struct packed {
		logic              active;
		logic [FUNC_W-1:0] func;
		logic              hit;
		logic              hit_writer;
		logic              free_found;
	} tok_flags_t;

	// Control part of the update that is broadcast to all cells.
	typedef struct packed {
		logic en;
		logic valid;
		logic writer;
	} upd_t;

endpackage
`default_nettype wire

FILE: sv/rwlt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reader/writer lock table: lock cell
// Holds one table entry. The lookup word from the previous cell is merged
// with this entry and registered on its way to the next cell.
// ----------------------------------------------------------------------------
module rwlt_cell #(
	parameter int IDX        = 0,
	parameter int IDX_W      = 4,
	parameter int KEY_BITS   = 32,
	parameter int COUNT_BITS = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire rwlt_pkg::tok_flags_t in_flags,
	input  wire  [KEY_BITS-1:0]       in_key,
	input  wire  [IDX_W-1:0]          in_hit_idx,
	input  wire  [COUNT_BITS-1:0]     in_hit_readers,
	input  wire  [IDX_W-1:0]          in_free_idx,
	output rwlt_pkg::tok_flags_t      out_flags,
	output logic [KEY_BITS-1:0]       out_key,
	output logic [IDX_W-1:0]          out_hit_idx,
	output logic [COUNT_BITS-1:0]     out_hit_readers,
	output logic [IDX_W-1:0]          out_free_idx,
	input  wire rwlt_pkg::upd_t       upd,
	input  wire  [IDX_W-1:0]          upd_idx,
	input  wire  [KEY_BITS-1:0]       upd_key,
	input  wire  [COUNT_BITS-1:0]     upd_readers
);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] readers_q;
	logic                  writer_q;

	rwlt_pkg::tok_flags_t  flags_d;
	logic [IDX_W-1:0]      hit_idx_d;
	logic [COUNT_BITS-1:0] hit_readers_d;
	logic [IDX_W-1:0]      free_idx_d;
	logic                  match;
	logic                  sel;

	assign match = valid_q && (key_q == in_key);
	assign sel   = upd.en && (upd_idx == IDX_W'(IDX));

	always_comb begin
		flags_d       = in_flags;
		hit_idx_d     = in_hit_idx;
		hit_readers_d = in_hit_readers;
		free_idx_d    = in_free_idx;
		if (match && !in_flags.hit) begin
			flags_d.hit        = 1'b1;
			flags_d.hit_writer = writer_q;
			hit_idx_d          = IDX_W'(IDX);
			hit_readers_d      = readers_q;
		end
		// Only the lowest free slot is kept for a later insert.
		if (!valid_q && !in_flags.free_found) begin
			flags_d.free_found = 1'b1;
			free_idx_d         = IDX_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_flags <= '0;
		end else begin
			out_flags <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		out_key         <= in_key;
		out_hit_idx     <= hit_idx_d;
		out_hit_readers <= hit_readers_d;
		out_free_idx    <= free_idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			valid_q <= upd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			key_q     <= upd_key;
			readers_q <= upd_readers;
			writer_q  <= upd.writer;
		end
	end

endmodule
`default_nettype wire

FILE: sv/reader_writer_lock_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reader/writer lock table
// Table of shared/exclusive locks keyed by a resource key, built as a row
// of lock cells that a lookup word walks through.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (func, key) is taken at a rising edge where start is high
//   and busy is low. busy then stays high until the lookup has passed every
//   cell. The lookup word enters cell 0 at the accepting edge and moves one
//   cell per cycle; once it has left the last cell, the
//   next edge applies the update to the chosen cell and registers the
//   result word. done is high for exactly that one following cycle, with
//   granted, table_full, reader_count and write_held valid alongside it.
//   The receiver cannot stall; a result word is shown once and is gone.
//   A new request can be taken at the edge that ends the cycle in which done
//   is high, so only one request is in the cell row at a time.
//   Reset clears all entry valid bits at once and leaves the block idle;
//   key and count storage is written on allocation.
// ----------------------------------------------------------------------------
module reader_writer_lock_table_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int COUNT_BITS = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire  [rwlt_pkg::FUNC_W-1:0]        func,
	input  wire  [rwlt_pkg::KEY_IN_W-1:0]      key,
	output logic                               done,
	output logic                               granted,
	output logic                               table_full,
	output logic [rwlt_pkg::CNT_OUT_W-1:0]     reader_count,
	output logic                               write_held
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int KIN_W = (KEY_BITS < rwlt_pkg::KEY_IN_W) ? KEY_BITS : rwlt_pkg::KEY_IN_W;
	localparam int CO_W  = (COUNT_BITS < rwlt_pkg::CNT_OUT_W) ? COUNT_BITS : rwlt_pkg::CNT_OUT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	rwlt_pkg::tok_flags_t  flags_c     [0:ENTRIES];
	logic [KEY_BITS-1:0]   key_c       [0:ENTRIES];
	logic [IDX_W-1:0]      hit_idx_c   [0:ENTRIES];
	logic [COUNT_BITS-1:0] hit_rd_c    [0:ENTRIES];
	logic [IDX_W-1:0]      free_idx_c  [0:ENTRIES];

	rwlt_pkg::upd_t        upd;
	logic [IDX_W-1:0]      upd_idx;
	logic [COUNT_BITS-1:0] upd_readers;

	logic                  busy_q;
	logic                  done_q;
	logic                  accept;

	// Result of the tail computation.
	rwlt_pkg::tok_flags_t  tf;
	logic                  ins;
	logic                  alloc;
	logic                  present;
	logic                  full;
	logic                  grant;
	logic [COUNT_BITS-1:0] rd;
	logic                  wr;

	assign accept = start && !busy_q;
	assign busy   = busy_q;
	assign done   = done_q;

	always_comb begin
		flags_c[0]            = '0;
		flags_c[0].active     = accept;
		flags_c[0].func       = func;
	end
	assign key_c[0]      = KEY_BITS'(key[KIN_W-1:0]);
	assign hit_idx_c[0]  = '0;
	assign hit_rd_c[0]   = '0;
	assign free_idx_c[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		rwlt_cell #(
			.IDX        (i),
			.IDX_W      (IDX_W),
			.KEY_BITS   (KEY_BITS),
			.COUNT_BITS (COUNT_BITS)
		) u_cell (
			.clk             (clk),
			.arst_n          (arst_n),
			.in_flags        (flags_c[i]),
			.in_key          (key_c[i]),
			.in_hit_idx      (hit_idx_c[i]),
			.in_hit_readers  (hit_rd_c[i]),
			.in_free_idx     (free_idx_c[i]),
			.out_flags       (flags_c[i+1]),
			.out_key         (key_c[i+1]),
			.out_hit_idx     (hit_idx_c[i+1]),
			.out_hit_readers (hit_rd_c[i+1]),
			.out_free_idx    (free_idx_c[i+1]),
			.upd             (upd),
			.upd_idx         (upd_idx),
			.upd_key         (key_c[ENTRIES]),
			.upd_readers     (upd_readers)
		);
	end

	assign tf = flags_c[ENTRIES];

	always_comb begin
		ins = (tf.func == rwlt_pkg::FN_REGISTER) || (tf.func == rwlt_pkg::FN_ACQ_READ) ||
		      (tf.func == rwlt_pkg::FN_ACQ_WRITE);
		alloc   = ins && !tf.hit;
		full    = alloc && !tf.free_found;
		present = tf.hit || (alloc && tf.free_found);
		upd_idx = tf.hit ? hit_idx_c[ENTRIES] : free_idx_c[ENTRIES];
		// A freshly allocated entry starts with no holders.
		rd      = tf.hit ? hit_rd_c[ENTRIES] : '0;
		wr      = tf.hit && tf.hit_writer;
		grant   = 1'b0;
		upd.en  = tf.active && present;
		case (tf.func)
			rwlt_pkg::FN_REGISTER: begin
				grant = present;
			end
			rwlt_pkg::FN_DROP: begin
				if (present && !wr && rd == '0) begin
					present = 1'b0;
				end
				grant = present;
			end
			rwlt_pkg::FN_ACQ_READ: begin
				if (present && !wr && rd != COUNT_MAX) begin
					rd    = rd + COUNT_BITS'(1);
					grant = 1'b1;
				end
			end
			rwlt_pkg::FN_REL_READ: begin
				if (present && !wr) begin
					if (rd != '0) begin
						rd = rd - COUNT_BITS'(1);
					end
					grant = 1'b1;
				end
			end
			rwlt_pkg::FN_ACQ_WRITE: begin
				if (present && !wr && rd == '0) begin
					wr    = 1'b1;
					grant = 1'b1;
				end
			end
			rwlt_pkg::FN_REL_WRITE: begin
				if (present && wr) begin
					wr    = 1'b0;
					grant = 1'b1;
				end
			end
			default: begin
				grant = 1'b0;
			end
		endcase
		upd.valid   = present;
		upd.writer  = wr;
		upd_readers = rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= tf.active;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tf.active) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tf.active) begin
			granted      <= grant;
			table_full   <= full;
			reader_count <= present ? rwlt_pkg::CNT_OUT_W'(rd[CO_W-1:0]) : '0;
			write_held   <= present && wr;
		end
	end

	// A result word always ends the request, so the block is idle with it.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result shown while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after accepting a request");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && table_full) |-> (!granted && !write_held && reader_count == '0))
		else $error("full table reported with a live entry");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && write_held) |-> (reader_count == '0))
		else $error("writer and readers hold the same entry");

endmodule
`default_nettype wire
